// ===== rtl/core/rsa_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_pkg
// shared constants, codes and types of the replicate slot allocator
// -----------------------------------------------------------------------------
package rsa_pkg;

	localparam int MAX_CORES            = 64;
	localparam int MAX_SLOTS_PER_CORE   = 8;
	localparam int MAX_DEVICES          = 8;
	localparam int MAX_SLOTS_PER_DEVICE = 8;
	localparam int REPLICATE_ID_BITS    = 16;

	localparam int CORE_ENTRIES = MAX_CORES * MAX_SLOTS_PER_CORE;
	localparam int DEV_ENTRIES  = MAX_DEVICES * MAX_SLOTS_PER_DEVICE;
	localparam int CORE_AW      = $clog2(CORE_ENTRIES);
	localparam int DEV_AW       = $clog2(DEV_ENTRIES);
	localparam int CLR_N        = (CORE_ENTRIES > DEV_ENTRIES) ? CORE_ENTRIES : DEV_ENTRIES;
	localparam int CLR_W        = $clog2(CLR_N);
	localparam int ID_W         = REPLICATE_ID_BITS;

	// walk counters must reach the largest core, slot or device count
	localparam int WALK_MAX_A = (MAX_CORES > MAX_DEVICES) ? MAX_CORES : MAX_DEVICES;
	localparam int WALK_MAX_B = (MAX_SLOTS_PER_CORE > MAX_SLOTS_PER_DEVICE) ?
		MAX_SLOTS_PER_CORE : MAX_SLOTS_PER_DEVICE;
	localparam int WALK_MAX   = (WALK_MAX_A > WALK_MAX_B) ? WALK_MAX_A : WALK_MAX_B;
	localparam int WALK_W     = $clog2(WALK_MAX + 1);

	// field widths of the ports
	localparam int OP_W       = 2;
	localparam int RID_W      = 16;
	localparam int STATUS_W   = 2;
	localparam int CMASK_W    = 64;
	localparam int GMASK_W    = 8;
	localparam int RCORE_W    = 6;
	localparam int MAXR_W     = 10;
	localparam int MAXR_SAT   = 1023;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam int CORE_CNT_W = 7;
	localparam int CSLOT_W    = 4;
	localparam int CPU_SPR_W  = 7;
	localparam int DEV_CNT_W  = 4;
	localparam int DSLOT_W    = 4;
	localparam int GPU_SPR_W  = 4;
	localparam int RCNT_W     = 7;
	localparam int RCNT_SAT   = 127;

	// divider operands for the max replicate figure
	localparam int NUM_MAX_C = MAX_SLOTS_PER_CORE * MAX_CORES;
	localparam int NUM_MAX_D = MAX_SLOTS_PER_DEVICE * MAX_DEVICES;
	localparam int NUM_W     = $clog2(((NUM_MAX_C > NUM_MAX_D) ? NUM_MAX_C : NUM_MAX_D) + 1);
	localparam int DEN_W     = CPU_SPR_W;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ASSIGN  = 2'd0,
		OP_RESERVE = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_NO_RES  = 2'd1,
		STS_NO_CORE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_FREE     = 2'd0,
		KIND_OWNED    = 2'd1,
		KIND_RESERVED = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CPU_CORE_COUNT     = 3'd0,
		REG_CPU_SLOTS_PER_CORE = 3'd1,
		REG_CPU_SLOTS_PER_REP  = 3'd2,
		REG_GPU_DEVICE_COUNT   = 3'd3,
		REG_GPU_SLOTS_PER_DEV  = 3'd4,
		REG_GPU_SLOTS_PER_REP  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		WALK_CASN,
		WALK_DASN,
		WALK_CFREE,
		WALK_DFREE,
		WALK_RCHK,
		WALK_RWR
	} walk_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_RWR,
		ST_CHECK,
		ST_DIV_C,
		ST_DIV_WC,
		ST_DIV_D,
		ST_DIV_WD,
		ST_DONE
	} fsm_state_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] owner;
	} entry_t;

	typedef struct packed {
		logic [CORE_CNT_W-1:0] core_count;
		logic [CSLOT_W-1:0]    slots_per_core;
		logic [CPU_SPR_W-1:0]  cpu_spr;
		logic [DEV_CNT_W-1:0]  dev_count;
		logic [DSLOT_W-1:0]    slots_per_dev;
		logic [GPU_SPR_W-1:0]  gpu_spr;
	} cfg_t;

	typedef struct packed {
		walk_t mode;
		logic  clr;
		logic  init;
		logic  walk_start;
		logic  rd;
		logic  ev;
		logic  row_start;
		logic  wr_row;
		logic  res_commit;
		logic  no_core;
		logic  fail;
		logic  div_go;
		logic  div_sel_gpu;
		logic  div_take;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic done;
		logic hit;
		logic short_res;
		logic div_busy;
		logic out_free;
	} stat_t;

	// count saturated to the table size
	function automatic logic [WALK_W-1:0] sat(input logic [CFG_DATA_W-1:0] v, input int hi);
		logic [WALK_W-1:0] r;
		if (int'(v) > hi) r = WALK_W'(hi);
		else r = WALK_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rsa_req_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_req_if
// request channel: op and replicate id
// -----------------------------------------------------------------------------
interface rsa_req_if;
	logic                     valid;
	logic                     ready;
	logic [rsa_pkg::OP_W-1:0]  op;
	logic [rsa_pkg::RID_W-1:0] replicate_id;

	modport source (output valid, output op, output replicate_id, input ready);
	modport sink (input valid, input op, input replicate_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsa_rsp_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_rsp_if
// result channel: status, masks, reserved core and max replicates
// -----------------------------------------------------------------------------
interface rsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rsa_pkg::STATUS_W-1:0] status;
	logic [rsa_pkg::CMASK_W-1:0]  cpu_core_mask;
	logic [rsa_pkg::GMASK_W-1:0]  gpu_device_mask;
	logic [rsa_pkg::RCORE_W-1:0]  reserved_core;
	logic [rsa_pkg::MAXR_W-1:0]   max_replicates;

	modport source (output valid, output status, output cpu_core_mask,
		output gpu_device_mask, output reserved_core, output max_replicates, input ready);
	modport sink (input valid, input status, input cpu_core_mask,
		input gpu_device_mask, input reserved_core, input max_replicates, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsa_cfg_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_cfg_if
// configuration write channel: register index and data
// -----------------------------------------------------------------------------
interface rsa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rsa_pkg::CFG_IDX_W-1:0]  index;
	logic [rsa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsa_div.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_div
// restoring divider, one quotient bit per cycle
// -----------------------------------------------------------------------------
module rsa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rsa_pkg::NUM_W-1:0] num,
	input  wire logic [rsa_pkg::DEN_W-1:0] den,
	output logic                           busy,
	output logic [rsa_pkg::NUM_W-1:0]      quot
);
	logic                          busy_q;
	logic [rsa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rsa_pkg::NUM_W-1:0]     num_q;
	logic [rsa_pkg::DEN_W:0]       rem_q;
	logic [rsa_pkg::DEN_W-1:0]     den_q;
	logic [rsa_pkg::DEN_W:0]       rem_sh;
	logic                          qbit;
	logic [rsa_pkg::DEN_W:0]       rem_nx;

	always_comb begin
		rem_sh = {rem_q[rsa_pkg::DEN_W-1:0], num_q[rsa_pkg::NUM_W-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
		rem_nx = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + rsa_pkg::DIV_CNT_W'(1);
			if (cnt_q == rsa_pkg::DIV_CNT_W'(rsa_pkg::NUM_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[rsa_pkg::NUM_W-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

	assign busy = busy_q;
	assign quot = num_q;
endmodule
`default_nettype wire

// ===== rtl/core/rsa_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_ctrl
// sequencer: table clear, assign/reserve/remove walks, divide, result hand-off
// -----------------------------------------------------------------------------
module rsa_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [rsa_pkg::OP_W-1:0] in_op,
	output logic                          in_ready,
	input  wire rsa_pkg::stat_t           st,
	output rsa_pkg::cmd_t                 cmd
);
	rsa_pkg::fsm_state_t state_q, state_d;
	rsa_pkg::walk_t      mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::ST_CLEAR;
			mode_q  <= rsa_pkg::WALK_CASN;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		cmd      = '0;
		cmd.mode = mode_q;
		in_ready = 1'b0;
		case (state_q)
			rsa_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_d = rsa_pkg::ST_IDLE;
			end
			rsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.init       = 1'b1;
					cmd.walk_start = 1'b1;
					case (rsa_pkg::op_t'(in_op))
						rsa_pkg::OP_ASSIGN: begin
							mode_d  = rsa_pkg::WALK_CASN;
							state_d = rsa_pkg::ST_RD;
						end
						rsa_pkg::OP_RESERVE: begin
							mode_d  = rsa_pkg::WALK_RCHK;
							state_d = rsa_pkg::ST_RD;
						end
						rsa_pkg::OP_REMOVE: begin
							mode_d  = rsa_pkg::WALK_CFREE;
							state_d = rsa_pkg::ST_RD;
						end
						default: state_d = rsa_pkg::ST_DIV_C;
					endcase
				end
			end
			rsa_pkg::ST_RD: begin
				if (st.hit) begin
					mode_d        = rsa_pkg::WALK_RWR;
					cmd.row_start = 1'b1;
					state_d       = rsa_pkg::ST_RWR;
				end else if (st.done) begin
					case (mode_q)
						rsa_pkg::WALK_CASN: begin
							mode_d         = rsa_pkg::WALK_DASN;
							cmd.walk_start = 1'b1;
						end
						rsa_pkg::WALK_DASN: state_d = rsa_pkg::ST_CHECK;
						rsa_pkg::WALK_CFREE: begin
							mode_d         = rsa_pkg::WALK_DFREE;
							cmd.walk_start = 1'b1;
						end
						rsa_pkg::WALK_RCHK: begin
							cmd.no_core = 1'b1;
							state_d     = rsa_pkg::ST_DIV_C;
						end
						default: state_d = rsa_pkg::ST_DIV_C;
					endcase
				end else begin
					cmd.rd  = 1'b1;
					state_d = rsa_pkg::ST_EV;
				end
			end
			rsa_pkg::ST_EV: begin
				cmd.ev  = 1'b1;
				state_d = rsa_pkg::ST_RD;
			end
			rsa_pkg::ST_RWR: begin
				if (st.done) begin
					cmd.res_commit = 1'b1;
					state_d        = rsa_pkg::ST_DIV_C;
				end else begin
					cmd.wr_row = 1'b1;
				end
			end
			rsa_pkg::ST_CHECK: begin
				if (st.short_res) begin
					cmd.fail       = 1'b1;
					cmd.walk_start = 1'b1;
					mode_d         = rsa_pkg::WALK_CFREE;
					state_d        = rsa_pkg::ST_RD;
				end else begin
					state_d = rsa_pkg::ST_DIV_C;
				end
			end
			rsa_pkg::ST_DIV_C: begin
				cmd.div_go = 1'b1;
				state_d    = rsa_pkg::ST_DIV_WC;
			end
			rsa_pkg::ST_DIV_WC: begin
				if (!st.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = rsa_pkg::ST_DIV_D;
				end
			end
			rsa_pkg::ST_DIV_D: begin
				cmd.div_go      = 1'b1;
				cmd.div_sel_gpu = 1'b1;
				state_d         = rsa_pkg::ST_DIV_WD;
			end
			rsa_pkg::ST_DIV_WD: begin
				cmd.div_sel_gpu = 1'b1;
				if (!st.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = rsa_pkg::ST_DONE;
				end
			end
			rsa_pkg::ST_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = rsa_pkg::ST_IDLE;
				end
			end
			default: state_d = rsa_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/rsa_dp.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// rsa_dp
// slot tables, walk counters, result assembly and max replicate divide
// -----------------------------------------------------------------------------
module rsa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rsa_pkg::cfg_t                 cfg,
	input  wire rsa_pkg::cmd_t                 cmd,
	output rsa_pkg::stat_t                     st,
	input  wire logic [rsa_pkg::RID_W-1:0]     in_id,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [rsa_pkg::STATUS_W-1:0]       out_status,
	output logic [rsa_pkg::CMASK_W-1:0]        out_cmask,
	output logic [rsa_pkg::GMASK_W-1:0]        out_gmask,
	output logic [rsa_pkg::RCORE_W-1:0]        out_rcore,
	output logic [rsa_pkg::MAXR_W-1:0]         out_maxr
);
	localparam int W = rsa_pkg::WALK_W;

	rsa_pkg::entry_t core_mem [rsa_pkg::CORE_ENTRIES];
	rsa_pkg::entry_t dev_mem [rsa_pkg::DEV_ENTRIES];
	rsa_pkg::entry_t core_rd_q, dev_rd_q, ent, core_wd, dev_wd;
	logic [rsa_pkg::CORE_AW-1:0] core_addr, core_wa;
	logic [rsa_pkg::DEV_AW-1:0]  dev_addr, dev_wa;
	logic core_we, dev_we;

	logic [rsa_pkg::CLR_W-1:0] clr_q;
	logic [W-1:0] o_q, n_q, ol, il, nc, ncs, nd, nds, res, row_i, col_j;
	logic hit_q, stop, is_free, id_hit;
	logic [rsa_pkg::CPU_SPR_W-1:0] got_c_q;
	logic [rsa_pkg::GPU_SPR_W-1:0] got_d_q;
	logic [rsa_pkg::RCNT_W-1:0]    rcnt_q;
	logic [rsa_pkg::ID_W-1:0]      id_q;
	rsa_pkg::status_t              sts_q;
	logic [rsa_pkg::CMASK_W-1:0]   cmask_q;
	logic [rsa_pkg::GMASK_W-1:0]   gmask_q;
	logic [rsa_pkg::RCORE_W-1:0]   rcore_q;
	logic [rsa_pkg::NUM_W-1:0]     qc_q, qd_q, div_num, div_quot, r;
	logic [rsa_pkg::DEN_W-1:0]     div_den;
	logic                          div_busy;
	logic [rsa_pkg::MAXR_W-1:0]    maxr;

	logic                          out_valid_q;
	rsa_pkg::status_t              o_sts_q;
	logic [rsa_pkg::CMASK_W-1:0]   o_cmask_q;
	logic [rsa_pkg::GMASK_W-1:0]   o_gmask_q;
	logic [rsa_pkg::RCORE_W-1:0]   o_rcore_q;
	logic [rsa_pkg::MAXR_W-1:0]    o_maxr_q;

	// usable counts
	always_comb begin
		nc  = rsa_pkg::sat(rsa_pkg::CFG_DATA_W'(cfg.core_count), rsa_pkg::MAX_CORES);
		ncs = rsa_pkg::sat(rsa_pkg::CFG_DATA_W'(cfg.slots_per_core), rsa_pkg::MAX_SLOTS_PER_CORE);
		nd  = rsa_pkg::sat(rsa_pkg::CFG_DATA_W'(cfg.dev_count), rsa_pkg::MAX_DEVICES);
		nds = rsa_pkg::sat(rsa_pkg::CFG_DATA_W'(cfg.slots_per_dev), rsa_pkg::MAX_SLOTS_PER_DEVICE);
		res = (W'(rcnt_q) > nc) ? nc : W'(rcnt_q);
	end

	// walk limits and addressing; assign walks are slot-major
	always_comb begin
		case (cmd.mode)
			rsa_pkg::WALK_CASN: begin
				ol = ncs;
				il = nc;
			end
			rsa_pkg::WALK_DASN: begin
				ol = nds;
				il = nd;
			end
			rsa_pkg::WALK_DFREE: begin
				ol = nd;
				il = nds;
			end
			default: begin
				ol = nc;
				il = ncs;
			end
		endcase
		if (cmd.mode == rsa_pkg::WALK_CASN || cmd.mode == rsa_pkg::WALK_DASN) begin
			row_i = n_q;
			col_j = o_q;
		end else begin
			row_i = o_q;
			col_j = n_q;
		end
		core_addr = rsa_pkg::CORE_AW'(int'(row_i) * rsa_pkg::MAX_SLOTS_PER_CORE + int'(col_j));
		dev_addr  = rsa_pkg::DEV_AW'(int'(row_i) * rsa_pkg::MAX_SLOTS_PER_DEVICE + int'(col_j));
		stop = (cmd.mode == rsa_pkg::WALK_CASN && got_c_q >= cfg.cpu_spr) ||
			(cmd.mode == rsa_pkg::WALK_DASN && got_d_q >= cfg.gpu_spr);
		ent = (cmd.mode == rsa_pkg::WALK_DASN || cmd.mode == rsa_pkg::WALK_DFREE) ?
			dev_rd_q : core_rd_q;
		is_free = (ent.kind == rsa_pkg::KIND_FREE);
		id_hit  = (ent.kind == rsa_pkg::KIND_OWNED) && (ent.owner == id_q);
	end

	always_comb begin
		st.clr_last  = (clr_q == rsa_pkg::CLR_W'(rsa_pkg::CLR_N - 1));
		st.done      = (cmd.mode == rsa_pkg::WALK_RWR) ? (n_q >= il) :
			((o_q >= ol) || (il == '0) || stop);
		st.hit       = (cmd.mode == rsa_pkg::WALK_RCHK) &&
			(hit_q || (il == '0 && o_q < ol));
		st.short_res = (got_c_q != cfg.cpu_spr) || (got_d_q != cfg.gpu_spr);
		st.div_busy  = div_busy;
		st.out_free  = !out_valid_q || out_ready;
	end

	// table write port
	always_comb begin
		core_we = 1'b0;
		core_wa = core_addr;
		core_wd = '{kind: rsa_pkg::KIND_OWNED, owner: id_q};
		dev_we  = 1'b0;
		dev_wa  = dev_addr;
		dev_wd  = '{kind: rsa_pkg::KIND_OWNED, owner: id_q};
		if (cmd.clr) begin
			core_we = (int'(clr_q) < rsa_pkg::CORE_ENTRIES);
			core_wa = rsa_pkg::CORE_AW'(clr_q);
			core_wd = '{kind: rsa_pkg::KIND_FREE, owner: '0};
			dev_we  = (int'(clr_q) < rsa_pkg::DEV_ENTRIES);
			dev_wa  = rsa_pkg::DEV_AW'(clr_q);
			dev_wd  = '{kind: rsa_pkg::KIND_FREE, owner: '0};
		end else if (cmd.wr_row) begin
			core_we = 1'b1;
			core_wd = '{kind: rsa_pkg::KIND_RESERVED, owner: '0};
		end else if (cmd.ev) begin
			case (cmd.mode)
				rsa_pkg::WALK_CASN: core_we = is_free;
				rsa_pkg::WALK_DASN: dev_we = is_free;
				rsa_pkg::WALK_CFREE: begin
					core_we = id_hit;
					core_wd = '{kind: rsa_pkg::KIND_FREE, owner: '0};
				end
				rsa_pkg::WALK_DFREE: begin
					dev_we = id_hit;
					dev_wd = '{kind: rsa_pkg::KIND_FREE, owner: '0};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (core_we) core_mem[core_wa] <= core_wd;
		if (dev_we) dev_mem[dev_wa] <= dev_wd;
		if (cmd.rd) begin
			core_rd_q <= core_mem[core_addr];
			dev_rd_q  <= dev_mem[dev_addr];
		end
	end

	// walk counters and per-item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			o_q     <= '0;
			n_q     <= '0;
			hit_q   <= 1'b0;
			got_c_q <= '0;
			got_d_q <= '0;
			rcnt_q  <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + rsa_pkg::CLR_W'(1);
			if (cmd.init) begin
				got_c_q <= '0;
				got_d_q <= '0;
			end
			if (cmd.walk_start) begin
				o_q   <= '0;
				n_q   <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.row_start) n_q <= '0;
			if (cmd.wr_row) n_q <= n_q + W'(1);
			if (cmd.ev) begin
				if (cmd.mode == rsa_pkg::WALK_RCHK) begin
					if (!is_free) begin
						o_q <= o_q + W'(1);
						n_q <= '0;
					end else if (n_q + W'(1) == il) begin
						hit_q <= 1'b1;
					end else begin
						n_q <= n_q + W'(1);
					end
				end else begin
					if (n_q + W'(1) == il) begin
						n_q <= '0;
						o_q <= o_q + W'(1);
					end else begin
						n_q <= n_q + W'(1);
					end
					if (cmd.mode == rsa_pkg::WALK_CASN && is_free)
						got_c_q <= got_c_q + rsa_pkg::CPU_SPR_W'(1);
					if (cmd.mode == rsa_pkg::WALK_DASN && is_free)
						got_d_q <= got_d_q + rsa_pkg::GPU_SPR_W'(1);
				end
			end
			if (cmd.res_commit && int'(rcnt_q) < rsa_pkg::RCNT_SAT)
				rcnt_q <= rcnt_q + rsa_pkg::RCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			id_q    <= rsa_pkg::ID_W'(in_id);
			sts_q   <= rsa_pkg::STS_OK;
			cmask_q <= '0;
			gmask_q <= '0;
			rcore_q <= '0;
		end
		if (cmd.ev && is_free) begin
			if (cmd.mode == rsa_pkg::WALK_CASN) cmask_q[n_q[rsa_pkg::RCORE_W-1:0]] <= 1'b1;
			if (cmd.mode == rsa_pkg::WALK_DASN && int'(n_q) < rsa_pkg::GMASK_W)
				gmask_q[n_q[$clog2(rsa_pkg::GMASK_W)-1:0]] <= 1'b1;
		end
		if (cmd.res_commit) rcore_q <= rsa_pkg::RCORE_W'(o_q);
		if (cmd.no_core) sts_q <= rsa_pkg::STS_NO_CORE;
		if (cmd.fail) begin
			sts_q   <= rsa_pkg::STS_NO_RES;
			cmask_q <= '0;
			gmask_q <= '0;
		end
		if (cmd.div_take) begin
			if (cmd.div_sel_gpu) qd_q <= div_quot;
			else qc_q <= div_quot;
		end
	end

	// shared divider for the processor and device replicate counts
	always_comb begin
		if (cmd.div_sel_gpu) begin
			div_num = rsa_pkg::NUM_W'(nds) * rsa_pkg::NUM_W'(nd);
			div_den = rsa_pkg::DEN_W'(cfg.gpu_spr);
		end else begin
			div_num = rsa_pkg::NUM_W'(ncs) * rsa_pkg::NUM_W'(nc - res);
			div_den = cfg.cpu_spr;
		end
	end

	rsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		if (cfg.cpu_spr != '0 && cfg.gpu_spr != '0) r = (qc_q < qd_q) ? qc_q : qd_q;
		else if (cfg.cpu_spr != '0) r = qc_q;
		else if (cfg.gpu_spr != '0) r = qd_q;
		else r = '0;
		maxr = (int'(r) > rsa_pkg::MAXR_SAT) ? rsa_pkg::MAXR_W'(rsa_pkg::MAXR_SAT) :
			rsa_pkg::MAXR_W'(r);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_sts_q   <= sts_q;
			o_cmask_q <= cmask_q;
			o_gmask_q <= gmask_q;
			o_rcore_q <= rcore_q;
			o_maxr_q  <= maxr;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = o_sts_q;
	assign out_cmask  = o_cmask_q;
	assign out_gmask  = o_gmask_q;
	assign out_rcore  = o_rcore_q;
	assign out_maxr   = o_maxr_q;

	a_fail_masks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && o_sts_q != rsa_pkg::STS_OK |-> o_cmask_q == '0 && o_gmask_q == '0)
		else $error("failed request carries a nonzero mask");
	a_rcnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> rcnt_q >= $past(rcnt_q))
		else $error("reserved core count went down");
	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev |-> $past(cmd.rd))
		else $error("table entry evaluated without a read the cycle before");
endmodule
`default_nettype wire

// ===== rtl/core/replicate_slot_allocator.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// replicate_slot_allocator
// core and device slot allocation for replicates, one request at a time
// -----------------------------------------------------------------------------
// After reset the block clears both slot tables and takes
// no request until that is done (configuration writes are taken throughout).
// One request then runs alone: each table entry visited takes a registered
// read, then an update. Assign walks the core slots, then the device slots,
// and when it fails a release pass walks both tables again; reserve checks
// core slots, then marks the slots of the core that it found; remove walks
// the core and device slots in range; query walks nothing. Every request
// ends with two serial divides for max_replicates. The next request is
// accepted as soon as the result is latched, even if the result has not
// been taken yet.
module replicate_slot_allocator (
	input  wire logic clk,
	input  wire logic arst_n,
	rsa_req_if.sink   req,
	rsa_rsp_if.source rsp,
	rsa_cfg_if.sink   cfg
);
	rsa_pkg::cfg_t  cfg_q;
	rsa_pkg::cmd_t  cmd;
	rsa_pkg::stat_t st;

	// configuration registers, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (rsa_pkg::cfg_reg_t'(cfg.index))
				rsa_pkg::REG_CPU_CORE_COUNT:
					cfg_q.core_count <= cfg.data[rsa_pkg::CORE_CNT_W-1:0];
				rsa_pkg::REG_CPU_SLOTS_PER_CORE:
					cfg_q.slots_per_core <= cfg.data[rsa_pkg::CSLOT_W-1:0];
				rsa_pkg::REG_CPU_SLOTS_PER_REP:
					cfg_q.cpu_spr <= cfg.data[rsa_pkg::CPU_SPR_W-1:0];
				rsa_pkg::REG_GPU_DEVICE_COUNT:
					cfg_q.dev_count <= cfg.data[rsa_pkg::DEV_CNT_W-1:0];
				rsa_pkg::REG_GPU_SLOTS_PER_DEV:
					cfg_q.slots_per_dev <= cfg.data[rsa_pkg::DSLOT_W-1:0];
				rsa_pkg::REG_GPU_SLOTS_PER_REP:
					cfg_q.gpu_spr <= cfg.data[rsa_pkg::GPU_SPR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: owns request acceptance and the walk order
	rsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// tables, counters and the result register
	rsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.st         (st),
		.in_id      (req.replicate_id),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_cmask  (rsp.cpu_core_mask),
		.out_gmask  (rsp.gpu_device_mask),
		.out_rcore  (rsp.reserved_core),
		.out_maxr   (rsp.max_replicates)
	);
endmodule
`default_nettype wire

// ===== sim/replicate_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// replicate_slot_allocator_tb
// self-checking bench: requests go through the request channel, every result
// is compared with a slot-table model kept in the bench, configuration is
// changed only between phases while the block is idle
// -----------------------------------------------------------------------------
module replicate_slot_allocator_tb;
	import rsa_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CMASK_W-1:0]  cmask;
		logic [GMASK_W-1:0]  gmask;
		logic [RCORE_W-1:0]  rcore;
		logic [MAXR_W-1:0]   maxr;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	rsa_req_if req ();
	rsa_rsp_if rsp ();
	rsa_cfg_if cfg ();

	replicate_slot_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// bench copy of the slot tables and registers
	kind_t           core_kind  [CORE_ENTRIES];
	logic [ID_W-1:0] core_owner [CORE_ENTRIES];
	kind_t           dev_kind   [DEV_ENTRIES];
	logic [ID_W-1:0] dev_owner  [DEV_ENTRIES];
	int              rsv_count;
	int              reg_core_cnt, reg_cslots, reg_cspr, reg_dev_cnt, reg_dslots, reg_dspr;

	alloc_result_t expected_q [$];

	int errors;
	int n_requests;
	int n_results;
	int n_fail_assign;
	int n_no_core;
	int snd_idle;
	int rcv_idle;
	int hold_left;

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int clampi(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	// release every in-range entry that the id owns
	function automatic void release_id(input logic [ID_W-1:0] id);
		int k;
		for (int i = 0; i < clampi(reg_core_cnt, MAX_CORES); i++)
			for (int j = 0; j < clampi(reg_cslots, MAX_SLOTS_PER_CORE); j++) begin
				k = i * MAX_SLOTS_PER_CORE + j;
				if (core_kind[k] == KIND_OWNED && core_owner[k] == id) core_kind[k] = KIND_FREE;
			end
		for (int i = 0; i < clampi(reg_dev_cnt, MAX_DEVICES); i++)
			for (int j = 0; j < clampi(reg_dslots, MAX_SLOTS_PER_DEVICE); j++) begin
				k = i * MAX_SLOTS_PER_DEVICE + j;
				if (dev_kind[k] == KIND_OWNED && dev_owner[k] == id) dev_kind[k] = KIND_FREE;
			end
	endfunction

	function automatic int replicate_capacity();
		int cores, rsv, cpu, gpu, r;
		cores = clampi(reg_core_cnt, MAX_CORES);
		rsv   = (rsv_count > cores) ? cores : rsv_count;
		cpu   = 0;
		gpu   = 0;
		if (reg_cspr > 0) cpu = clampi(reg_cslots, MAX_SLOTS_PER_CORE) * (cores - rsv) / reg_cspr;
		if (reg_dspr > 0)
			gpu = clampi(reg_dslots, MAX_SLOTS_PER_DEVICE) * clampi(reg_dev_cnt, MAX_DEVICES)
				/ reg_dspr;
		if (reg_cspr > 0 && reg_dspr == 0) r = cpu;
		else if (reg_cspr == 0 && reg_dspr > 0) r = gpu;
		else if (reg_cspr > 0 && reg_dspr > 0) r = (cpu < gpu) ? cpu : gpu;
		else r = 0;
		return clampi(r, MAXR_SAT);
	endfunction

	// one request applied to the bench tables, returns the result it must give
	function automatic alloc_result_t allocate_step(input op_t op, input logic [ID_W-1:0] id);
		alloc_result_t r;
		int got, gotd, k, nc, ns, nd, nds;
		bit found, all_free;
		r   = '0;
		nc  = clampi(reg_core_cnt, MAX_CORES);
		ns  = clampi(reg_cslots, MAX_SLOTS_PER_CORE);
		nd  = clampi(reg_dev_cnt, MAX_DEVICES);
		nds = clampi(reg_dslots, MAX_SLOTS_PER_DEVICE);
		r.status = STS_OK;
		case (op)
			OP_ASSIGN: begin
				got  = 0;
				gotd = 0;
				// slot index outer, core inner
				for (int j = 0; j < ns && got < reg_cspr; j++)
					for (int i = 0; i < nc && got < reg_cspr; i++) begin
						k = i * MAX_SLOTS_PER_CORE + j;
						if (core_kind[k] == KIND_FREE) begin
							core_kind[k]  = KIND_OWNED;
							core_owner[k] = id;
							r.cmask[i]    = 1'b1;
							got++;
						end
					end
				for (int j = 0; j < nds && gotd < reg_dspr; j++)
					for (int i = 0; i < nd && gotd < reg_dspr; i++) begin
						k = i * MAX_SLOTS_PER_DEVICE + j;
						if (dev_kind[k] == KIND_FREE) begin
							dev_kind[k]  = KIND_OWNED;
							dev_owner[k] = id;
							if (i < GMASK_W) r.gmask[i] = 1'b1;
							gotd++;
						end
					end
				if (got != reg_cspr || gotd != reg_dspr) begin
					// failure also drops whatever the id held before
					release_id(id);
					r.status = STS_NO_RES;
					r.cmask  = '0;
					r.gmask  = '0;
				end
			end
			OP_RESERVE: begin
				found = 0;
				for (int i = 0; i < nc && !found; i++) begin
					all_free = 1;
					for (int j = 0; j < ns; j++)
						if (core_kind[i * MAX_SLOTS_PER_CORE + j] != KIND_FREE) all_free = 0;
					if (all_free) begin
						for (int j = 0; j < ns; j++) core_kind[i * MAX_SLOTS_PER_CORE + j] = KIND_RESERVED;
						if (rsv_count < RCNT_SAT) rsv_count++;
						r.rcore = RCORE_W'(i);
						found   = 1;
					end
				end
				if (!found) r.status = STS_NO_CORE;
			end
			OP_REMOVE: release_id(id);
			default: ;
		endcase
		r.maxr = MAXR_W'(replicate_capacity());
		return r;
	endfunction

	// one request: optional gap, then hold valid until accepted
	task automatic send_request(input op_t op, input logic [ID_W-1:0] id);
		alloc_result_t r;
		if ($urandom_range(99) < snd_idle) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.op           <= op;
		req.replicate_id <= id;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		r = allocate_step(op, id);
		expected_q.insert(expected_q.size(), r);
		n_requests++;
	endtask

	// wait until every result is in, then let the block settle
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_CPU_CORE_COUNT:     reg_core_cnt = val & 8'h7f;
			REG_CPU_SLOTS_PER_CORE: reg_cslots   = val & 8'h0f;
			REG_CPU_SLOTS_PER_REP:  reg_cspr     = val & 8'h7f;
			REG_GPU_DEVICE_COUNT:   reg_dev_cnt  = val & 8'h0f;
			REG_GPU_SLOTS_PER_DEV:  reg_dslots   = val & 8'h0f;
			REG_GPU_SLOTS_PER_REP:  reg_dspr     = val & 8'h0f;
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int cc, input int cs, input int cspr,
		input int dc, input int ds, input int dspr);
		write_reg(REG_CPU_CORE_COUNT, cc[7:0]);
		write_reg(REG_CPU_SLOTS_PER_CORE, cs[7:0]);
		write_reg(REG_CPU_SLOTS_PER_REP, cspr[7:0]);
		write_reg(REG_GPU_DEVICE_COUNT, dc[7:0]);
		write_reg(REG_GPU_SLOTS_PER_DEV, ds[7:0]);
		write_reg(REG_GPU_SLOTS_PER_REP, dspr[7:0]);
	endtask

	// result checker and receiver stall generator
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result at %0t", $time);
			end else begin
				e = expected_q.pop_front();
				if (e.status == STS_NO_RES) n_fail_assign++;
				if (e.status == STS_NO_CORE) n_no_core++;
				if (rsp.status !== e.status || rsp.cpu_core_mask !== e.cmask
					|| rsp.gpu_device_mask !== e.gmask || rsp.reserved_core !== e.rcore
					|| rsp.max_replicates !== e.maxr) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch at %0t: exp sts %0d cm %h gm %h rc %0d mr %0d,",
							" got sts %0d cm %h gm %h rc %0d mr %0d"},
							$time, e.status, e.cmask, e.gmask, e.rcore, e.maxr,
							rsp.status, rsp.cpu_core_mask, rsp.gpu_device_mask,
							rsp.reserved_core, rsp.max_replicates);
				end
			end
		end
		// long hold-off first, otherwise random stalls
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// after reset nothing is configured: every op answers with zero capacity
	task automatic test_unconfigured();
		send_request(OP_QUERY, 16'h0000);
		send_request(OP_ASSIGN, 16'hffff);
		send_request(OP_RESERVE, 16'h0000);
		send_request(OP_REMOVE, 16'hffff);
		wait_drained();
	endtask

	// every op, id extremes, zero need, failed assign, oversized counts
	task automatic test_directed();
		set_config(4, 2, 1, 2, 2, 1);
		send_request(OP_ASSIGN, 16'h0000);
		send_request(OP_ASSIGN, 16'hffff);
		send_request(OP_ASSIGN, 16'h0000);
		send_request(OP_RESERVE, 16'h1234);
		send_request(OP_QUERY, 16'h5555);
		send_request(OP_ASSIGN, 16'haaaa);
		send_request(OP_ASSIGN, 16'h0001);
		send_request(OP_REMOVE, 16'h0000);
		send_request(OP_REMOVE, 16'hffff);
		wait_drained();
		// zero need on both sides succeeds with empty masks
		set_config(4, 2, 0, 2, 2, 0);
		send_request(OP_ASSIGN, 16'h0042);
		wait_drained();
		// need larger than what is left, then than the table; the failure also drops earlier holdings
		set_config(4, 2, 3, 2, 2, 1);
		send_request(OP_ASSIGN, 16'h0007);
		send_request(OP_ASSIGN, 16'h0007);
		send_request(OP_ASSIGN, 16'h0008);
		send_request(OP_ASSIGN, 16'h0009);
		wait_drained();
		write_reg(REG_CPU_SLOTS_PER_REP, 8'd127);
		send_request(OP_ASSIGN, 16'h0007);
		wait_drained();
		// oversized counts saturate, all-ones data
		set_config(255, 255, 1, 255, 255, 15);
		send_request(OP_ASSIGN, 16'h0010);
		send_request(OP_RESERVE, 16'h0000);
		send_request(OP_REMOVE, 16'h0010);
		wait_drained();
		// largest legal setting
		set_config(64, 8, 1, 8, 8, 1);
		send_request(OP_ASSIGN, 16'h0020);
		send_request(OP_RESERVE, 16'h0000);
		send_request(OP_QUERY, 16'h0000);
		wait_drained();
	endtask

	// zero slots per core: the first core is reserved over and over, count saturates
	task automatic test_reserve_saturation();
		set_config(2, 0, 1, 1, 1, 1);
		for (int n = 0; n < 132; n++) send_request(OP_RESERVE, 16'(n));
		send_request(OP_QUERY, 16'h0000);
		wait_drained();
		// more reserved than cores: capacity uses zero cores
		set_config(3, 4, 1, 0, 0, 0);
		send_request(OP_QUERY, 16'h0000);
		wait_drained();
	endtask

	task automatic random_config();
		int cc, cs, cspr, dc, ds, dspr;
		if ($urandom_range(5) == 0) begin
			// an extreme setting, sometimes with raw 8-bit data
			cc   = $urandom_range(1) ? 64 : $urandom_range(255);
			cs   = $urandom_range(1) ? 8 : $urandom_range(255);
			cspr = $urandom_range(1) ? 1 : $urandom_range(255);
			dc   = $urandom_range(1) ? 8 : $urandom_range(255);
			ds   = $urandom_range(1) ? 8 : $urandom_range(255);
			dspr = $urandom_range(1) ? 1 : $urandom_range(255);
		end else begin
			cc   = $urandom_range(1, 12);
			cs   = $urandom_range(0, 4);
			cspr = (cs > 1) ? $urandom_range(0, 2) : $urandom_range(0, cc + 2);
			dc   = $urandom_range(0, 8);
			ds   = $urandom_range(0, 4);
			dspr = (ds > 1) ? $urandom_range(0, 2) : $urandom_range(0, dc + 1);
		end
		set_config(cc, cs, cspr, dc, ds, dspr);
	endtask

	// random ops on a small id pool so that removes and repeats hit live ids
	task automatic test_random_phase(input int n_items);
		int pick;
		logic [ID_W-1:0] id;
		random_config();
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			id   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
			if (pick < 45) send_request(OP_ASSIGN, id);
			else if (pick < 75) send_request(OP_REMOVE, id);
			else if (pick < 85) send_request(OP_RESERVE, id);
			else send_request(OP_QUERY, id);
		end
		wait_drained();
	endtask

	// receiver holds off while requests keep coming, the block must stall
	task automatic test_backpressure();
		set_config(2, 1, 1, 0, 0, 0);
		@(posedge clk);
		hold_left = 400;
		for (int n = 0; n < 20; n++) send_request(OP_QUERY, 16'(n));
		wait_drained();
	endtask

	initial begin
		errors        = 0;
		n_requests    = 0;
		n_results     = 0;
		n_fail_assign = 0;
		n_no_core     = 0;
		hold_left     = 0;
		snd_idle      = 26;
		rcv_idle      = 50;
		rsv_count     = 0;
		reg_core_cnt  = 0;
		reg_cslots    = 0;
		reg_cspr      = 0;
		reg_dev_cnt   = 0;
		reg_dslots    = 0;
		reg_dspr      = 0;
		for (int k = 0; k < CORE_ENTRIES; k++) begin
			core_kind[k]  = KIND_FREE;
			core_owner[k] = '0;
		end
		for (int k = 0; k < DEV_ENTRIES; k++) begin
			dev_kind[k]  = KIND_FREE;
			dev_owner[k] = '0;
		end
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.op           = OP_QUERY;
		req.replicate_id = '0;
		cfg.valid        = 1'b0;
		cfg.index        = REG_CPU_CORE_COUNT;
		cfg.data         = '0;
		rsp.ready        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unconfigured();
		test_directed();
		test_reserve_saturation();
		test_backpressure();
		// three idling patterns, several settings each
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				snd_idle = 50;
				rcv_idle = 26;
			end
			if (p == 6) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			test_random_phase(170);
		end

		$display("covered %0d requests, %0d results, %0d failed assigns, %0d reserve misses",
			n_requests, n_results, n_fail_assign, n_no_core);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("mismatches: %0d", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#100ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
